// ===== src/landing_sequence_controller_unit_defines.svh =====
// Assertion macros shared by the landing sequence controller RTL.
`ifndef LANDING_SEQUENCE_CONTROLLER_UNIT_DEFINES_SVH
`define LANDING_SEQUENCE_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LSC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lsc_pkg.sv =====
// Types, codes and constant tables of the landing sequence controller.
`default_nettype none

package lsc_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int REG_W          = 16;
    localparam int CFG_ADDR_W     = 3;
    localparam int IN_TDATA_W     = 80;
    localparam int OUT_TDATA_W    = 64;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_WAIT   = 3'd1,
        PH_ADJUST = 3'd2,
        PH_CIRCLE = 3'd3,
        PH_LAND   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_HOLD     = 3'd1,
        CMD_BODY_VEL = 3'd2,
        CMD_CIRCLE   = 3'd3,
        CMD_LAND     = 3'd4
    } cmd_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } op_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DETECT_THRESHOLD = 3'd0,
        REG_WAIT_TICKS       = 3'd1,
        REG_LOSS_TICKS       = 3'd2,
        REG_LANDING_TICKS    = 3'd3,
        REG_MIN_ALTITUDE     = 3'd4
    } reg_idx_t;

    localparam logic [REG_W-1:0] DETECT_THRESHOLD_RST = 16'd30;
    localparam logic [REG_W-1:0] WAIT_TICKS_RST       = 16'd250;
    localparam logic [REG_W-1:0] LOSS_TICKS_RST       = 16'd150;
    localparam logic [REG_W-1:0] LANDING_TICKS_RST    = 16'd250;
    localparam logic [REG_W-1:0] MIN_ALTITUDE_RST     = 16'd100;

    // Descent bands, 50 cm each, the last one open upward.
    localparam int BAND_STEP_CM = 50;
    localparam logic [6:0] BAND_TOL [0:6] = '{7'd30, 7'd40, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80};
    localparam logic [9:0] BAND_DOWN [0:6] =
        '{10'd150, 10'd150, 10'd200, 10'd200, 10'd250, 10'd250, 10'd300};
    localparam logic [9:0] DOWN_SLOW    = 10'd10;
    localparam logic [9:0] DOWN_LANDING = 10'd200;

    typedef struct packed {
        logic [REG_W-1:0] detect_threshold;
        logic [REG_W-1:0] wait_ticks;
        logic [REG_W-1:0] loss_ticks;
        logic [REG_W-1:0] landing_ticks;
        logic [REG_W-1:0] min_altitude_cm;
    } cfg_t;

    typedef struct packed {
        op_t                operation;
        logic               marker_found;
        logic signed [11:0] err_x;
        logic signed [11:0] err_y;
        logic [15:0]        altitude_cm;
        logic signed [15:0] track_vx;
        logic signed [15:0] track_vy;
    } item_t;

    typedef struct packed {
        cmd_t               command;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic [9:0]         vel_down;
        logic [15:0]        circle_elapsed;
        phase_t             phase;
        logic               start_refused;
    } result_t;

    // Altitude band index: altitude / 50, capped at the last band.
    function automatic logic [2:0] band_level(input logic [15:0] alt);
        logic [2:0] lvl;
        if (alt < 16'(BAND_STEP_CM)) lvl = 3'd0;
        else if (alt < 16'(2 * BAND_STEP_CM)) lvl = 3'd1;
        else if (alt < 16'(3 * BAND_STEP_CM)) lvl = 3'd2;
        else if (alt < 16'(4 * BAND_STEP_CM)) lvl = 3'd3;
        else if (alt < 16'(5 * BAND_STEP_CM)) lvl = 3'd4;
        else if (alt < 16'(6 * BAND_STEP_CM)) lvl = 3'd5;
        else lvl = 3'd6;
        return lvl;
    endfunction

endpackage

`default_nettype wire

// ===== src/lsc_descent.sv =====
// Descent speed lookup for the adjust phase from altitude band and marker error.
`default_nettype none

module lsc_descent (
    input  wire logic [15:0]        altitude_cm,
    input  wire logic signed [11:0] err_x,
    input  wire logic signed [11:0] err_y,
    output logic [9:0]              vel_down
);

    logic [2:0]  lvl;
    logic [12:0] abs_x;
    logic [12:0] abs_y;
    logic [12:0] tol;

    always_comb begin
        lvl   = lsc_pkg::band_level(altitude_cm);
        abs_x = err_x[11] ? (13'd0 - {err_x[11], err_x}) : {1'b0, err_x};
        abs_y = err_y[11] ? (13'd0 - {err_y[11], err_y}) : {1'b0, err_y};
        tol   = {6'd0, lsc_pkg::BAND_TOL[lvl]};
        // Full band speed only when the marker is well centered.
        if (abs_x < tol && abs_y < tol) begin
            vel_down = lsc_pkg::BAND_DOWN[lvl];
        end else begin
            vel_down = lsc_pkg::DOWN_SLOW;
        end
    end

endmodule

`default_nettype wire

// ===== src/lsc_step.sv =====
// Next-state and command logic for one request of the landing sequencer.
`default_nettype none

module lsc_step #(
    parameter int TIMER_BITS = lsc_pkg::TIMER_BITS_DEF
) (
    input  wire lsc_pkg::item_t         item,
    input  wire lsc_pkg::cfg_t          cfg,
    input  wire lsc_pkg::phase_t        phase,
    input  wire lsc_pkg::phase_t        prev_phase,
    input  wire logic                   running,
    input  wire logic [TIMER_BITS-1:0]  wait_timer,
    input  wire logic [15:0]            sight_count,
    input  wire logic                   loss_flag,
    input  wire logic [TIMER_BITS-1:0]  loss_timer,
    input  wire logic                   landing_armed,
    input  wire logic [TIMER_BITS-1:0]  landing_timer,
    input  wire logic [TIMER_BITS-1:0]  circle_timer,
    output lsc_pkg::phase_t             phase_next,
    output lsc_pkg::phase_t             prev_phase_next,
    output logic                        running_next,
    output logic [TIMER_BITS-1:0]       wait_timer_next,
    output logic [15:0]                 sight_count_next,
    output logic                        loss_flag_next,
    output logic [TIMER_BITS-1:0]       loss_timer_next,
    output logic                        landing_armed_next,
    output logic [TIMER_BITS-1:0]       landing_timer_next,
    output logic [TIMER_BITS-1:0]       circle_timer_next,
    output lsc_pkg::result_t            result
);

    localparam int CMP_W = (TIMER_BITS > lsc_pkg::REG_W) ? TIMER_BITS : lsc_pkg::REG_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
    localparam logic [TIMER_BITS-1:0] TIMER_ONE = TIMER_BITS'(1);

    logic [9:0]            band_down;
    logic                  entering;
    logic [TIMER_BITS-1:0] wait_eff;
    logic [TIMER_BITS-1:0] circle_eff;
    logic [TIMER_BITS-1:0] land_eff;
    logic                  above_min;

    lsc_descent u_descent (
        .altitude_cm (item.altitude_cm),
        .err_x       (item.err_x),
        .err_y       (item.err_y),
        .vel_down    (band_down)
    );

    always_comb begin
        phase_next         = phase;
        prev_phase_next    = prev_phase;
        running_next       = running;
        wait_timer_next    = wait_timer;
        sight_count_next   = sight_count;
        loss_flag_next     = loss_flag;
        loss_timer_next    = loss_timer;
        landing_armed_next = landing_armed;
        landing_timer_next = landing_timer;
        circle_timer_next  = circle_timer;

        result                = '0;
        result.command        = lsc_pkg::CMD_NONE;

        // Phase entry timer clears apply on ticks only.
        entering   = (phase != prev_phase);
        wait_eff   = (entering && phase == lsc_pkg::PH_WAIT) ? '0 : wait_timer;
        circle_eff = (entering && phase == lsc_pkg::PH_CIRCLE) ? '0 : circle_timer;
        land_eff   = landing_armed ? landing_timer : '0;
        above_min  = (item.altitude_cm > cfg.min_altitude_cm);

        if (item.operation == lsc_pkg::OP_START) begin
            if (!running) begin
                phase_next     = lsc_pkg::PH_WAIT;
                running_next   = 1'b1;
                loss_flag_next = 1'b0;
            end else begin
                result.start_refused = 1'b1;
            end
        end else begin
            prev_phase_next   = phase;
            wait_timer_next   = wait_eff;
            circle_timer_next = circle_eff;
            if (running) begin
                unique case (phase)
                    lsc_pkg::PH_WAIT: begin
                        result.command = lsc_pkg::CMD_HOLD;
                        if (CMP_W'(wait_eff) >= CMP_W'(cfg.wait_ticks)) begin
                            phase_next = (sight_count > cfg.detect_threshold) ?
                                         lsc_pkg::PH_ADJUST : lsc_pkg::PH_CIRCLE;
                            sight_count_next = '0;
                        end else if (item.marker_found && sight_count != 16'hFFFF) begin
                            sight_count_next = sight_count + 16'd1;
                        end
                        wait_timer_next = (wait_eff == TIMER_MAX) ? wait_eff
                                                                  : wait_eff + TIMER_ONE;
                    end
                    lsc_pkg::PH_ADJUST: begin
                        if (!above_min) begin
                            phase_next = lsc_pkg::PH_LAND;
                        end else if (item.marker_found) begin
                            result.command  = lsc_pkg::CMD_BODY_VEL;
                            result.vel_x    = item.track_vx;
                            result.vel_y    = item.track_vy;
                            result.vel_down = band_down;
                            loss_flag_next  = 1'b0;
                        end else if (!loss_flag) begin
                            loss_flag_next  = 1'b1;
                            loss_timer_next = TIMER_ONE;
                        end else if (CMP_W'(loss_timer) >= CMP_W'(cfg.loss_ticks)) begin
                            phase_next     = lsc_pkg::PH_CIRCLE;
                            loss_flag_next = 1'b0;
                        end else begin
                            loss_timer_next = (loss_timer == TIMER_MAX) ? loss_timer
                                                                        : loss_timer + TIMER_ONE;
                        end
                    end
                    lsc_pkg::PH_CIRCLE: begin
                        if (!above_min) begin
                            phase_next = lsc_pkg::PH_LAND;
                        end else begin
                            result.command = lsc_pkg::CMD_CIRCLE;
                            result.circle_elapsed =
                                (CMP_W'(circle_eff) > CMP_W'(16'hFFFF)) ? 16'hFFFF
                                                                        : 16'(circle_eff);
                            circle_timer_next = (circle_eff == TIMER_MAX) ? circle_eff
                                                                          : circle_eff + TIMER_ONE;
                            if (item.marker_found) begin
                                phase_next = lsc_pkg::PH_ADJUST;
                            end
                        end
                    end
                    lsc_pkg::PH_LAND: begin
                        landing_armed_next = 1'b1;
                        landing_timer_next = land_eff;
                        if (above_min && CMP_W'(land_eff) < CMP_W'(cfg.landing_ticks)) begin
                            result.command  = lsc_pkg::CMD_BODY_VEL;
                            if (item.marker_found) begin
                                result.vel_x = item.track_vx;
                                result.vel_y = item.track_vy;
                            end
                            result.vel_down = lsc_pkg::DOWN_LANDING;
                            landing_timer_next = (land_eff == TIMER_MAX) ? land_eff
                                                                         : land_eff + TIMER_ONE;
                        end else begin
                            result.command     = lsc_pkg::CMD_LAND;
                            landing_armed_next = 1'b0;
                            running_next       = 1'b0;
                            phase_next         = lsc_pkg::PH_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        result.phase = phase_next;
    end

endmodule

`default_nettype wire

// ===== src/landing_sequence_controller_unit.sv =====
// Top level of the landing sequence controller: ports, registers and checks.
`default_nettype none

// Tick-driven precision landing sequencer. Each slave request is either a
// start command (s_tuser = 1) or one control tick (s_tuser = 0) carrying
// marker visibility, marker pixel errors, altitude and the tracking
// controller's velocities. For every request exactly one result leaves on the
// master side: a command (none, hold, body velocity, circle search, land and
// disarm) with its velocities, circle elapsed ticks, the phase after the
// request and a refused-start flag. A request is held in the input register
// and is evaluated in one pass of combinational logic into the result
// register. One request is accepted every cycle unless the result register
// is held by back pressure on m_tready, the only limit on rate, which the input
// register absorbs for one request. Timeouts count ticks, not time, in
// TIMER_BITS-wide saturating counters. The five 16-bit registers (detect
// threshold, wait ticks, loss ticks, landing ticks, minimum altitude) are
// written through cfg_wr_en/cfg_addr/cfg_wr_data, which should only be used
// while no request is in flight; addresses beyond the fifth are ignored.
// Reset is synchronous and active low.

`include "landing_sequence_controller_unit_defines.svh"

module landing_sequence_controller_unit #(
    parameter int TIMER_BITS = lsc_pkg::TIMER_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Slave request channel.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata, lowest bit up: marker_found(1), err_x(12), err_y(12),
    // altitude_cm(16), track_vx(16), track_vy(16), zero padding(7).
    input  wire logic [lsc_pkg::IN_TDATA_W-1:0]    s_tdata,
    // s_tuser: operation(1), 0 tick, 1 start.
    input  wire logic                              s_tuser,
    // Master result channel.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata, lowest bit up: vel_x(16), vel_y(16), vel_down(10),
    // circle_elapsed(16), phase(3), start_refused(1), zero padding(2).
    output logic [lsc_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // m_tuser: command(3).
    output logic [2:0]                             m_tuser,
    // Configuration write port.
    input  wire logic                              cfg_wr_en,
    input  wire logic [lsc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [lsc_pkg::REG_W-1:0]         cfg_wr_data
);

    lsc_pkg::cfg_t          cfg_reg;

    // Input register.
    logic                   in_valid_reg;
    lsc_pkg::item_t         in_item_reg;
    lsc_pkg::item_t         in_item_next;

    // Result register.
    logic                   out_valid_reg;
    lsc_pkg::result_t       out_result_reg;
    lsc_pkg::result_t       out_result_next;

    // Sequencer state.
    lsc_pkg::phase_t        phase_reg, phase_next;
    lsc_pkg::phase_t        prev_phase_reg, prev_phase_next;
    logic                   running_reg, running_next;
    logic [TIMER_BITS-1:0]  wait_timer_reg, wait_timer_next;
    logic [15:0]            sight_count_reg, sight_count_next;
    logic                   loss_flag_reg, loss_flag_next;
    logic [TIMER_BITS-1:0]  loss_timer_reg, loss_timer_next;
    logic                   landing_armed_reg, landing_armed_next;
    logic [TIMER_BITS-1:0]  landing_timer_reg, landing_timer_next;
    logic [TIMER_BITS-1:0]  circle_timer_reg, circle_timer_next;

    logic                   advance;

    // The held request moves into the result register when that register is
    // empty or its contents are being taken this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_item_next              = '0;
        in_item_next.operation    = lsc_pkg::op_t'(s_tuser);
        in_item_next.marker_found = s_tdata[0];
        in_item_next.err_x        = s_tdata[12:1];
        in_item_next.err_y        = s_tdata[24:13];
        in_item_next.altitude_cm  = s_tdata[40:25];
        in_item_next.track_vx     = s_tdata[56:41];
        in_item_next.track_vy     = s_tdata[72:57];
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.detect_threshold <= lsc_pkg::DETECT_THRESHOLD_RST;
            cfg_reg.wait_ticks       <= lsc_pkg::WAIT_TICKS_RST;
            cfg_reg.loss_ticks       <= lsc_pkg::LOSS_TICKS_RST;
            cfg_reg.landing_ticks    <= lsc_pkg::LANDING_TICKS_RST;
            cfg_reg.min_altitude_cm  <= lsc_pkg::MIN_ALTITUDE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                lsc_pkg::REG_DETECT_THRESHOLD: cfg_reg.detect_threshold <= cfg_wr_data;
                lsc_pkg::REG_WAIT_TICKS:       cfg_reg.wait_ticks       <= cfg_wr_data;
                lsc_pkg::REG_LOSS_TICKS:       cfg_reg.loss_ticks       <= cfg_wr_data;
                lsc_pkg::REG_LANDING_TICKS:    cfg_reg.landing_ticks    <= cfg_wr_data;
                lsc_pkg::REG_MIN_ALTITUDE:     cfg_reg.min_altitude_cm  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    lsc_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .item               (in_item_reg),
        .cfg                (cfg_reg),
        .phase              (phase_reg),
        .prev_phase         (prev_phase_reg),
        .running            (running_reg),
        .wait_timer         (wait_timer_reg),
        .sight_count        (sight_count_reg),
        .loss_flag          (loss_flag_reg),
        .loss_timer         (loss_timer_reg),
        .landing_armed      (landing_armed_reg),
        .landing_timer      (landing_timer_reg),
        .circle_timer       (circle_timer_reg),
        .phase_next         (phase_next),
        .prev_phase_next    (prev_phase_next),
        .running_next       (running_next),
        .wait_timer_next    (wait_timer_next),
        .sight_count_next   (sight_count_next),
        .loss_flag_next     (loss_flag_next),
        .loss_timer_next    (loss_timer_next),
        .landing_armed_next (landing_armed_next),
        .landing_timer_next (landing_timer_next),
        .circle_timer_next  (circle_timer_next),
        .result             (out_result_next)
    );

    // Handshake control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= in_item_next;
        end
        if (advance) begin
            out_result_reg <= out_result_next;
        end
    end

    // Sequencer state only moves when a request is evaluated.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= lsc_pkg::PH_IDLE;
            prev_phase_reg    <= lsc_pkg::PH_IDLE;
            running_reg       <= 1'b0;
            wait_timer_reg    <= '0;
            sight_count_reg   <= '0;
            loss_flag_reg     <= 1'b0;
            loss_timer_reg    <= '0;
            landing_armed_reg <= 1'b0;
            landing_timer_reg <= '0;
            circle_timer_reg  <= '0;
        end else if (advance) begin
            phase_reg         <= phase_next;
            prev_phase_reg    <= prev_phase_next;
            running_reg       <= running_next;
            wait_timer_reg    <= wait_timer_next;
            sight_count_reg   <= sight_count_next;
            loss_flag_reg     <= loss_flag_next;
            loss_timer_reg    <= loss_timer_next;
            landing_armed_reg <= landing_armed_next;
            landing_timer_reg <= landing_timer_next;
            circle_timer_reg  <= circle_timer_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.command;
    assign m_tdata  = {2'b00,
                       out_result_reg.start_refused,
                       out_result_reg.phase,
                       out_result_reg.circle_elapsed,
                       out_result_reg.vel_down,
                       out_result_reg.vel_y,
                       out_result_reg.vel_x};

    // A stopped sequence always rests in the idle phase.
    `LSC_ASSERT_NOW(a_idle_when_stopped, aclk, aresetn,
        !running_reg, phase_reg == lsc_pkg::PH_IDLE,
        "sequencer stopped outside the idle phase")

    // The landing timer is only armed while in the landing phase.
    `LSC_ASSERT_NOW(a_armed_in_landing, aclk, aresetn,
        landing_armed_reg, phase_reg == lsc_pkg::PH_LAND && running_reg,
        "landing armed outside the landing phase")

    // A start while running comes out refused, with no command.
    `LSC_ASSERT_NEXT(a_start_refused, aclk, aresetn,
        advance && in_item_reg.operation == lsc_pkg::OP_START && running_reg,
        m_tvalid && m_tdata[61] && m_tuser == lsc_pkg::CMD_NONE,
        "start while running was not refused")

    // Downward speed is only given with a body velocity command.
    `LSC_ASSERT_NOW(a_down_only_body_vel, aclk, aresetn,
        m_tvalid && m_tuser != lsc_pkg::CMD_BODY_VEL, m_tdata[41:32] == 10'd0,
        "descent speed outside a body velocity command")

endmodule

`default_nettype wire
